// ----- design/vtt_pkg.sv -----
package vtt_pkg;

  localparam int ID_W       = 14;
  localparam int TIME_W     = 32;
  localparam int TIMEOUT_W  = 16;
  localparam int OUT_CNT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [ID_W-1:0]      ID_LIMIT      = 14'd9999;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic {
    OP_RECORD    = 1'b0,
    OP_NO_TARGET = 1'b1
  } vtt_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_CLEAR   = 2'd1
  } vtt_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } vtt_state_t;

  // Beat walking down the chain of cells, one cell per cycle.
  typedef struct packed {
    logic                 valid;
    logic                 age_en;
    logic [ID_W-1:0]      id;
    logic [TIME_W-1:0]    now;
    logic [TIMEOUT_W-1:0] timeout;
    logic                 match;
    logic                 free_found;
  } vtt_tok_t;

  // Broadcast to every cell when an item completes.
  typedef struct packed {
    logic              insert;
    logic              clear_all;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] now;
  } vtt_cmt_t;

endpackage

// ----- design/vtt_cell.sv -----
module vtt_cell #(
  parameter int CNT_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  vtt_pkg::vtt_tok_t tok_in,
  input  logic [CNT_W-1:0]  exp_in,
  input  logic [CNT_W-1:0]  cnt_in,
  input  vtt_pkg::vtt_cmt_t cmt,
  output vtt_pkg::vtt_tok_t tok_out,
  output logic [CNT_W-1:0]  exp_out,
  output logic [CNT_W-1:0]  cnt_out
);

  logic                          valid;
  logic                          cand;
  logic [vtt_pkg::ID_W-1:0]      id;
  logic [vtt_pkg::TIME_W-1:0]    seen;

  logic [vtt_pkg::TIME_W-1:0]    age;
  logic                          expire;
  logic                          v_after;
  logic                          hit;
  logic                          claim;
  vtt_pkg::vtt_tok_t             tok_next;
  logic [CNT_W-1:0]              exp_next;
  logic [CNT_W-1:0]              cnt_next;

  always_comb begin
    age      = tok_in.now - seen;
    expire   = tok_in.age_en && valid &&
               (age > {{(vtt_pkg::TIME_W - vtt_pkg::TIMEOUT_W){1'b0}}, tok_in.timeout});
    v_after  = valid && !expire;
    hit      = tok_in.age_en && v_after && (id == tok_in.id) && !tok_in.match;
    claim    = tok_in.age_en && !v_after && !tok_in.free_found;
    tok_next = tok_in;
    tok_next.match      = tok_in.match || hit;
    tok_next.free_found = tok_in.free_found || claim;
    exp_next = exp_in + CNT_W'(expire);
    cnt_next = cnt_in + CNT_W'(v_after);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      exp_out <= '0;
      cnt_out <= '0;
    end else begin
      tok_out <= tok_next;
      exp_out <= exp_next;
      cnt_out <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cand  <= 1'b0;
    end else if (tok_in.valid) begin
      valid <= v_after;
      cand  <= claim;
    end else if (cmt.clear_all) begin
      valid <= 1'b0;
    end else if (cmt.insert && cand) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid && hit) begin
      seen <= tok_in.now;
    end else if (!tok_in.valid && cmt.insert && cand) begin
      seen <= cmt.now;
      id   <= cmt.id;
    end
  end

endmodule

// ----- design/vehicle_track_table_with_aging.sv -----
// Aging table of tracked target ids.
// Input channel (in_valid / in_stall) carries opcode, target_id and now_ms;
// a beat is taken when in_valid is high and in_stall is low. Each item gives
// exactly one result beat on the output channel (out_valid / out_stall).
// Configuration writes come over cfg_valid / cfg_ready with cfg_index and
// cfg_data: index 0 is timeout_ms, index 1 is clear_on_empty; other indexes
// are ignored. Write only while no item is in flight.
// A record walks a chain of MAX_TRACKED cells, one cell per cycle; each cell
// ages, refreshes or reserves its own slot. The beat leaving the last cell is
// captured in the summary registers as the state enters FINISH; the result
// register loads from FINISH once the output register is free. One item is in
// the chain at a time. The next item is taken while a result still waits in
// the output register; if the receiver stalls, the finished item holds until
// the output register frees, and in_stall stays high meanwhile.
// Reset empties the table, clears presence, and loads timeout_ms = 1000 and
// clear_on_empty = 0.
module vehicle_track_table_with_aging #(
  parameter int MAX_TRACKED = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            opcode,
  input  logic [vtt_pkg::ID_W-1:0]        target_id,
  input  logic [vtt_pkg::TIME_W-1:0]      now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            accepted,
  output logic [vtt_pkg::ID_W-1:0]        echo_id,
  output logic                            is_new,
  output logic                            table_full,
  output logic [vtt_pkg::OUT_CNT_W-1:0]   expired_count,
  output logic [vtt_pkg::OUT_CNT_W-1:0]   tracked_count,
  output logic                            target_present,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vtt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vtt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_TRACKED + 1);
  localparam int SAT_W = (CNT_W > vtt_pkg::OUT_CNT_W) ? CNT_W : vtt_pkg::OUT_CNT_W;

  vtt_pkg::vtt_state_t state, state_next;

  logic [vtt_pkg::TIMEOUT_W-1:0] timeout_ms;
  logic                          clear_on_empty;
  logic                          presence;

  logic                          item_op;
  logic [vtt_pkg::ID_W-1:0]      item_id;
  logic [vtt_pkg::TIME_W-1:0]    item_now;
  logic                          item_rec;

  logic                          sum_match;
  logic                          sum_free;
  logic [CNT_W-1:0]              sum_exp;
  logic [CNT_W-1:0]              sum_cnt;

  vtt_pkg::vtt_tok_t             tok [0:MAX_TRACKED];
  logic [CNT_W-1:0]              exp_c [0:MAX_TRACKED];
  logic [CNT_W-1:0]              cnt_c [0:MAX_TRACKED];
  vtt_pkg::vtt_cmt_t             cmt;

  logic                          in_accept;
  logic                          launch;
  logic                          finish;
  logic                          out_free;
  logic                          do_clear;
  logic [CNT_W-1:0]              tracked_next;
  logic [SAT_W-1:0]              exp_ext;
  logic [SAT_W-1:0]              trk_ext;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_accept = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms     <= vtt_pkg::TIMEOUT_RESET;
      clear_on_empty <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vtt_pkg::CFG_TIMEOUT: timeout_ms     <= cfg_data;
        vtt_pkg::CFG_CLEAR:   clear_on_empty <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      vtt_pkg::ST_IDLE:   if (in_accept) state_next = vtt_pkg::ST_SCAN;
      vtt_pkg::ST_SCAN:   if (tok[MAX_TRACKED].valid) state_next = vtt_pkg::ST_FINISH;
      vtt_pkg::ST_FINISH: if (out_free) state_next = vtt_pkg::ST_IDLE;
      default:            state_next = vtt_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall = 1'b1;
    launch   = 1'b0;
    finish   = 1'b0;
    case (state)
      vtt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        launch   = in_valid;
      end
      vtt_pkg::ST_SCAN:   ;
      vtt_pkg::ST_FINISH: finish = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vtt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the item for the completion step.
  always_ff @(posedge clk) begin
    if (launch) begin
      item_op  <= opcode;
      item_id  <= target_id;
      item_now <= now_ms;
    end
  end

  assign item_rec = (item_op == vtt_pkg::OP_RECORD) && (item_id <= vtt_pkg::ID_LIMIT);

  always_comb begin
    tok[0].valid      = launch;
    tok[0].age_en     = (opcode == vtt_pkg::OP_RECORD) && (target_id <= vtt_pkg::ID_LIMIT);
    tok[0].id         = target_id;
    tok[0].now        = now_ms;
    tok[0].timeout    = timeout_ms;
    tok[0].match      = 1'b0;
    tok[0].free_found = 1'b0;
    exp_c[0]          = '0;
    cnt_c[0]          = '0;
  end

  assign do_clear = (item_op == vtt_pkg::OP_NO_TARGET) && presence && clear_on_empty;

  always_comb begin
    cmt.insert    = finish && item_rec && !sum_match && sum_free;
    cmt.clear_all = finish && do_clear;
    cmt.id        = item_id;
    cmt.now       = item_now;
  end

  for (genvar i = 0; i < MAX_TRACKED; i++) begin : g_cell
    vtt_cell #(
      .CNT_W(CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .exp_in  (exp_c[i]),
      .cnt_in  (cnt_c[i]),
      .cmt     (cmt),
      .tok_out (tok[i+1]),
      .exp_out (exp_c[i+1]),
      .cnt_out (cnt_c[i+1])
    );
  end

  // Capture the beat leaving the last cell.
  always_ff @(posedge clk) begin
    if (tok[MAX_TRACKED].valid) begin
      sum_match <= tok[MAX_TRACKED].match;
      sum_free  <= tok[MAX_TRACKED].free_found;
      sum_exp   <= exp_c[MAX_TRACKED];
      sum_cnt   <= cnt_c[MAX_TRACKED];
    end
  end

  always_comb begin
    if (do_clear) begin
      tracked_next = '0;
    end else begin
      tracked_next = sum_cnt + CNT_W'(cmt.insert);
    end
    exp_ext = SAT_W'(sum_exp);
    trk_ext = SAT_W'(tracked_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      presence <= 1'b0;
    end else if (finish) begin
      if (item_rec) begin
        presence <= 1'b1;
      end else if (item_op == vtt_pkg::OP_NO_TARGET) begin
        presence <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      accepted      <= item_rec && (sum_match || sum_free);
      echo_id       <= (item_rec && (sum_match || sum_free)) ? item_id : '0;
      is_new        <= cmt.insert;
      table_full    <= item_rec && !sum_match && !sum_free;
      expired_count <= (exp_ext > SAT_W'(31)) ? vtt_pkg::OUT_CNT_W'(31)
                                              : exp_ext[vtt_pkg::OUT_CNT_W-1:0];
      tracked_count <= (trk_ext > SAT_W'(31)) ? vtt_pkg::OUT_CNT_W'(31)
                                              : trk_ext[vtt_pkg::OUT_CNT_W-1:0];
      target_present <= item_rec ? 1'b1
                      : (item_op == vtt_pkg::OP_NO_TARGET) ? 1'b0 : presence;
    end
  end

  a_chain_end_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[MAX_TRACKED].valid |-> state == vtt_pkg::ST_SCAN)
    else $error("beat left the chain outside a scan");

  a_finish_loads_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == vtt_pkg::ST_FINISH)
    else $error("result appeared without a completed item");

  a_new_is_accepted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_new && !accepted) && !(accepted && table_full))
    else $error("inconsistent result flags");

  a_no_launch_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state == vtt_pkg::ST_FINISH) |=> !tok[1].valid)
    else $error("new item entered the chain before completion");

endmodule
